/* hdl/tbp_pkg.sv */
// Shared types and codes for the trigram backoff predictor.
// No dependencies; used by tbp_argmax and trigram_backoff_predictor_core.
package tbp_pkg;

    // Field widths fixed by the stream format
    localparam int TOKEN_W  = 5;
    localparam int CTXLEN_W = 2;
    localparam int LEVEL_W  = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // Operation carried in s_axis_tuser
    localparam logic OP_TRAIN   = 1'b0;
    localparam logic OP_PREDICT = 1'b1;

    // Backoff level codes
    localparam logic [LEVEL_W-1:0] LVL_UNI = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_BI  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_TRI = 2'd2;

    // Control from the sequencer to the row scanner
    typedef struct packed {
        logic start;   // clear running best before a new row
        logic valid;   // read data of this cycle belongs to the row
    } scan_ctrl_t;

endpackage

/* hdl/trigram_backoff_predictor_core.sv */
// Top level of the trigram backoff predictor: sequencer, history and output register.
// Depends on tbp_pkg, tbp_ram and tbp_argmax.
//
// Usage:
//   Input stream (s_axis_*): s_axis_tuser selects train (0) or predict (1).
//   A train transaction counts one token and produces no output. A predict
//   transaction produces one output transaction with the chosen successor.
//   Output stream (m_axis_*): one transaction per predict item.
// Timing:
//   After reset the block sweeps the count memories to zero, one entry a
//   cycle, with s_axis_tready low. A train item is then accepted and passes
//   through three read-modify-write steps (read, unigram/trigram update,
//   bigram update). A predict item scans one table row per table searched,
//   up to 3 tables, reading one entry per cycle through the read port of
//   the count memories, then answers or backs off to the next table.
//   The result waits in an output register; a new item is accepted while it
//   waits, and the next prediction holds in its final step until the stalled
//   result has been taken.
module trigram_backoff_predictor_core #(
    parameter int VOCAB_SIZE = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [4:0] train_token, [5] seq_start, [7:6] context_len,
    // [12:8] context_prev, [17:13] context_last, [23:18] zero
    input  logic [tbp_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [4:0] predicted_token, [5] prediction_found, [7:6] backoff_level
    output logic [tbp_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam int TOK_W  = $clog2(VOCAB_SIZE);
    localparam int TRI_AW = 3 * TOK_W;
    localparam int LOW_AW = 2 * TOK_W + 1;
    localparam logic [TOK_W-1:0] LAST_IDX = TOK_W'(VOCAB_SIZE - 1);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_TR_RD   = 4'd2;
    localparam logic [3:0] S_TR_UNI  = 4'd3;
    localparam logic [3:0] S_TR_BI   = 4'd4;
    localparam logic [3:0] S_PR_SCAN = 4'd5;
    localparam logic [3:0] S_PR_LAST = 4'd6;
    localparam logic [3:0] S_PR_DEC  = 4'd7;

    // unpack input fields
    logic [tbp_pkg::TOKEN_W-1:0]  in_token;
    logic                         in_seq_start;
    logic [tbp_pkg::CTXLEN_W-1:0] in_ctx_len;
    logic [tbp_pkg::TOKEN_W-1:0]  in_ctx_prev;
    logic [tbp_pkg::TOKEN_W-1:0]  in_ctx_last;

    assign in_token     = s_axis_tdata[4:0];
    assign in_seq_start = s_axis_tdata[5];
    assign in_ctx_len   = s_axis_tdata[7:6];
    assign in_ctx_prev  = s_axis_tdata[12:8];
    assign in_ctx_last  = s_axis_tdata[17:13];

    logic tok_ok, prev_ok, last_ok;
    assign tok_ok  = (32'(in_token) < 32'(VOCAB_SIZE));
    assign prev_ok = (32'(in_ctx_prev) < 32'(VOCAB_SIZE));
    assign last_ok = (32'(in_ctx_last) < 32'(VOCAB_SIZE));

    logic [3:0]                  state_reg, state_next;
    logic [TRI_AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [TOK_W-1:0]            tok_reg, tok_next;
    logic [1:0]                  len_reg, len_next;
    logic [TOK_W-1:0]            ctx_prev_reg, ctx_prev_next;
    logic [TOK_W-1:0]            ctx_last_reg, ctx_last_next;
    logic                        bi_ok_reg, bi_ok_next;
    logic [tbp_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [TOK_W-1:0]            scan_idx_reg, scan_idx_next;
    logic                        data_valid_reg, data_valid_next;
    logic [TOK_W-1:0]            data_idx_reg, data_idx_next;
    logic [TOK_W-1:0]            hist_last_reg, hist_last_next;
    logic [TOK_W-1:0]            hist_prev_reg, hist_prev_next;
    logic [1:0]                  hist_len_reg, hist_len_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tbp_pkg::TOKEN_W-1:0] out_tok_reg, out_tok_next;
    logic                        out_found_reg, out_found_next;
    logic [tbp_pkg::LEVEL_W-1:0] out_level_reg, out_level_next;

    // memory ports
    logic                  tri_we, low_we;
    logic [TRI_AW-1:0]     tri_waddr, tri_raddr;
    logic [LOW_AW-1:0]     low_waddr, low_raddr;
    logic [COUNT_BITS-1:0] tri_wdata, low_wdata, tri_rdata, low_rdata;

    tbp_pkg::scan_ctrl_t   scan_ctrl;
    logic [TOK_W-1:0]      best_idx;
    logic                  best_nz;
    logic [COUNT_BITS-1:0] row_cnt;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        bump = (c != '1) ? c + COUNT_BITS'(1) : c;
    endfunction

    // training addresses
    logic [LOW_AW-1:0] uni_addr, bi_addr;
    logic [TRI_AW-1:0] tri_addr;
    assign uni_addr = {1'b0, {TOK_W{1'b0}}, tok_reg};
    assign bi_addr  = {1'b1, hist_last_reg, tok_reg};
    assign tri_addr = {hist_prev_reg, hist_last_reg, tok_reg};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign row_cnt = (level_reg == tbp_pkg::LVL_TRI) ? tri_rdata : low_rdata;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        tok_next        = tok_reg;
        len_next        = len_reg;
        ctx_prev_next   = ctx_prev_reg;
        ctx_last_next   = ctx_last_reg;
        bi_ok_next      = bi_ok_reg;
        level_next      = level_reg;
        scan_idx_next   = scan_idx_reg;
        data_valid_next = 1'b0;
        data_idx_next   = scan_idx_reg;
        hist_last_next  = hist_last_reg;
        hist_prev_next  = hist_prev_reg;
        hist_len_next   = hist_len_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_tok_next    = out_tok_reg;
        out_found_next  = out_found_reg;
        out_level_next  = out_level_reg;

        tri_we    = 1'b0;
        low_we    = 1'b0;
        tri_waddr = tri_addr;
        low_waddr = uni_addr;
        tri_wdata = bump(tri_rdata);
        low_wdata = bump(low_rdata);
        tri_raddr = tri_addr;
        low_raddr = uni_addr;

        scan_ctrl.start = 1'b0;
        scan_ctrl.valid = data_valid_reg;

        case (state_reg)
            S_CLEAR:
            begin
                tri_we    = 1'b1;
                low_we    = 1'b1;
                tri_waddr = clr_cnt_reg;
                low_waddr = clr_cnt_reg[LOW_AW-1:0];
                tri_wdata = '0;
                low_wdata = '0;
                clr_cnt_next = clr_cnt_reg + TRI_AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == tbp_pkg::OP_TRAIN)
                    begin
                        // out-of-vocabulary tokens are dropped
                        if (tok_ok)
                        begin
                            tok_next   = TOK_W'(in_token);
                            len_next   = in_seq_start ? 2'd0 : hist_len_reg;
                            state_next = S_TR_RD;
                        end
                    end
                    else
                    begin
                        ctx_prev_next   = TOK_W'(in_ctx_prev);
                        ctx_last_next   = TOK_W'(in_ctx_last);
                        bi_ok_next      = (in_ctx_len != 2'd0) && last_ok;
                        scan_idx_next   = '0;
                        scan_ctrl.start = 1'b1;
                        if (in_ctx_len[1] && prev_ok && last_ok)
                        begin
                            level_next = tbp_pkg::LVL_TRI;
                        end
                        else if ((in_ctx_len != 2'd0) && last_ok)
                        begin
                            level_next = tbp_pkg::LVL_BI;
                        end
                        else
                        begin
                            level_next = tbp_pkg::LVL_UNI;
                        end
                        state_next = S_PR_SCAN;
                    end
                end
            end
            S_TR_RD:
            begin
                state_next = S_TR_UNI;
            end
            S_TR_UNI:
            begin
                low_we     = 1'b1;
                tri_we     = (len_reg == 2'd2);
                low_raddr  = bi_addr;
                state_next = S_TR_BI;
            end
            S_TR_BI:
            begin
                low_we         = (len_reg != 2'd0);
                low_waddr      = bi_addr;
                hist_prev_next = hist_last_reg;
                hist_last_next = tok_reg;
                hist_len_next  = (len_reg == 2'd2) ? 2'd2 : len_reg + 2'd1;
                state_next     = S_IDLE;
            end
            S_PR_SCAN:
            begin
                tri_raddr = {ctx_prev_reg, ctx_last_reg, scan_idx_reg};
                if (level_reg == tbp_pkg::LVL_BI)
                begin
                    low_raddr = {1'b1, ctx_last_reg, scan_idx_reg};
                end
                else
                begin
                    low_raddr = {1'b0, {TOK_W{1'b0}}, scan_idx_reg};
                end
                data_valid_next = 1'b1;
                scan_idx_next   = scan_idx_reg + TOK_W'(1);
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_PR_LAST;
                end
            end
            S_PR_LAST:
            begin
                state_next = S_PR_DEC;
            end
            S_PR_DEC:
            begin
                if (best_nz || (level_reg == tbp_pkg::LVL_UNI))
                begin
                    // hold until the previous result has been taken
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = best_nz;
                        out_tok_next   = best_nz ? tbp_pkg::TOKEN_W'(best_idx) : '0;
                        out_level_next = best_nz ? level_reg : tbp_pkg::LVL_UNI;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    // back off to the next table
                    level_next = ((level_reg == tbp_pkg::LVL_TRI) && bi_ok_reg) ?
                                 tbp_pkg::LVL_BI : tbp_pkg::LVL_UNI;
                    scan_idx_next   = '0;
                    scan_ctrl.start = 1'b1;
                    state_next      = S_PR_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            data_valid_reg <= 1'b0;
            hist_last_reg  <= '0;
            hist_prev_reg  <= '0;
            hist_len_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            data_valid_reg <= data_valid_next;
            hist_last_reg  <= hist_last_next;
            hist_prev_reg  <= hist_prev_next;
            hist_len_reg   <= hist_len_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg      <= tok_next;
        len_reg      <= len_next;
        ctx_prev_reg <= ctx_prev_next;
        ctx_last_reg <= ctx_last_next;
        bi_ok_reg    <= bi_ok_next;
        level_reg    <= level_next;
        scan_idx_reg <= scan_idx_next;
        data_idx_reg <= data_idx_next;
        out_tok_reg   <= out_tok_next;
        out_found_reg <= out_found_next;
        out_level_reg <= out_level_next;
    end

    tbp_ram #(
        .WIDTH  (COUNT_BITS),
        .ADDR_W (TRI_AW)
    ) u_tri_ram (
        .clk   (clk),
        .we    (tri_we),
        .waddr (tri_waddr),
        .wdata (tri_wdata),
        .raddr (tri_raddr),
        .rdata (tri_rdata)
    );

    // bigram rows in the upper half, unigram row at the bottom
    tbp_ram #(
        .WIDTH  (COUNT_BITS),
        .ADDR_W (LOW_AW)
    ) u_low_ram (
        .clk   (clk),
        .we    (low_we),
        .waddr (low_waddr),
        .wdata (low_wdata),
        .raddr (low_raddr),
        .rdata (low_rdata)
    );

    tbp_argmax #(
        .IDX_W (TOK_W),
        .CNT_W (COUNT_BITS)
    ) u_argmax (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .idx      (data_idx_reg),
        .cnt      (row_cnt),
        .best_idx (best_idx),
        .best_nz  (best_nz)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_level_reg, out_found_reg, out_tok_reg};

endmodule

/* hdl/tbp_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies; holds the count tables of the predictor.
module tbp_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

/* hdl/tbp_argmax.sv */
// Running argmax over one row of counts streamed from a count memory.
// Depends on tbp_pkg (scan_ctrl_t).
module tbp_argmax #(
    parameter int IDX_W = 5,
    parameter int CNT_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tbp_pkg::scan_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    idx,
    input  logic [CNT_W-1:0]    cnt,
    output logic [IDX_W-1:0]    best_idx,
    output logic                best_nz
);

    logic [CNT_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0] pick_reg, pick_next;

    always_comb
    begin
        top_next  = top_reg;
        pick_next = pick_reg;
        if (ctrl.start)
        begin
            top_next  = '0;
            pick_next = '0;
        end
        else if (ctrl.valid && (cnt > top_reg))
        begin
            // strict compare keeps the smaller index on ties
            top_next  = cnt;
            pick_next = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            pick_reg <= '0;
        end
        else
        begin
            top_reg  <= top_next;
            pick_reg <= pick_next;
        end
    end

    assign best_idx = pick_reg;
    assign best_nz  = (top_reg != '0);

endmodule
